// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define RRTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RRTS_ASSERT(label, expr, msg)
`define RRTS_ASSERT_IMPL(label, ante, cons, msg)
`define RRTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rrts_pkg.sv -----
`default_nettype none
package rrts_pkg;
  localparam int unsigned IDX_W = 13;
  localparam int unsigned REC_W = 30;

  typedef logic [REC_W-1:0] rec_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_SORT   = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_SUM    = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NOENT = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [2:0] CH_HOLD   = 3'd0;
  localparam logic [2:0] CH_INSERT = 3'd1;
  localparam logic [2:0] CH_DELETE = 3'd2;
  localparam logic [2:0] CH_ROTATE = 3'd3;
  localparam logic [2:0] CH_SORT   = 3'd4;

  localparam logic REG_COMP_LIMIT = 1'b0;
  localparam logic REG_SUM_LIMIT  = 1'b1;

  localparam logic [9:0]  COMP_LIMIT_RST = 10'd1000;
  localparam logic [17:0] TOTAL_MAX      = 18'h3FFFF;

  typedef struct packed {
    logic [2:0] op;
    idx_t       count;
    idx_t       pos_m1;
    idx_t       u;
    rec_t       x;
    rec_t       din;
  } chain_ctrl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rrts_if.sv -----
`default_nettype none
interface rrts_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [9:0] red_in;
  logic [9:0] green_in;
  logic [9:0] blue_in;
  logic [8:0] position;
  modport source (output valid, command, red_in, green_in, blue_in, position, input ready);
  modport sink (input valid, command, red_in, green_in, blue_in, position, output ready);
endinterface

interface rrts_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  red_out;
  logic [9:0]  green_out;
  logic [9:0]  blue_out;
  logic [8:0]  entries_held;
  logic [17:0] red_total;
  logic [17:0] green_total;
  logic [17:0] blue_total;
  logic        red_over;
  logic        green_over;
  logic        blue_over;
  modport source (output valid, status, red_out, green_out, blue_out, entries_held,
                  red_total, green_total, blue_total, red_over, green_over, blue_over,
                  input ready);
  modport sink (input valid, status, red_out, green_out, blue_out, entries_held,
                red_total, green_total, blue_total, red_over, green_over, blue_over,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rrts_cell.sv -----
`default_nettype none
module rrts_cell import rrts_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire logic        clk,
  input  wire chain_ctrl_t ctrl,
  input  wire rec_t        right_val,
  input  wire logic        right_le,
  output rec_t             val_r,
  output logic             le
);
  localparam idx_t MY    = IDX_W'(IDX);
  localparam idx_t MY_P1 = IDX_W'(IDX + 1);

  rec_t val_nxt;
  logic right_ok;

  assign le       = (val_r <= ctrl.x);
  assign right_ok = (MY_P1 < ctrl.count) && right_le;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      CH_INSERT: begin
        if (MY == ctrl.count) val_nxt = ctrl.din;
      end
      CH_DELETE: begin
        if (MY >= ctrl.pos_m1) val_nxt = right_val;
      end
      CH_ROTATE: val_nxt = right_val;
      CH_SORT: begin
        // unsorted part moves toward the head, sorted tail takes the head item
        if (MY_P1 < ctrl.u) begin
          val_nxt = right_val;
        end else if (MY < ctrl.count) begin
          if (right_ok) val_nxt = right_val;
          else if (MY_P1 == ctrl.u || le) val_nxt = ctrl.x;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rrts_chain.sv -----
`default_nettype none
module rrts_chain import rrts_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic        clk,
  input  wire chain_ctrl_t ctrl,
  output rec_t             head
);
  rec_t vals [DEPTH];
  logic les  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      rrts_cell #(.IDX(i)) u_cell (
        .clk(clk), .ctrl(ctrl), .right_val(vals[i+1]), .right_le(les[i+1]),
        .val_r(vals[i]), .le(les[i])
      );
    end else begin : g_last
      // wrap to the head so a full walk restores the order
      rrts_cell #(.IDX(i)) u_cell (
        .clk(clk), .ctrl(ctrl), .right_val(vals[0]), .right_le(1'b0),
        .val_r(vals[i]), .le(les[i])
      );
    end
  end

  assign head = vals[0];
endmodule
`default_nettype wire

// ----- hw/rtl/rgb_record_table_sorter_core.sv -----
`default_nettype none
// Table of up to DEPTH color records held in a chain of cells, one record per cell,
// with cell 0 at the head. Commands: insert, delete, sort, read and sum check, each
// giving one result transaction. Insert and delete finish in one chain step. Sort
// runs one insertion step per stored record. Read and sum check rotate the whole
// chain past the head cell. One command is in flight at a time; a finished result
// waits in the output register until taken. Registers: component_limit at byte
// address 0 (reset 1000), sum_limit at address 4 (reset 262143).
module rgb_record_table_sorter_core import rrts_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rrts_cmd_if.sink         in_ch,
  rrts_res_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned HW = (CW > 9) ? CW : 9;
  localparam int unsigned SW = $clog2(DEPTH) + 10;
  localparam int unsigned TW = (SW > 18) ? SW : 18;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // configuration
  logic [9:0]  comp_limit_r;
  logic [17:0] sum_limit_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_limit_r <= COMP_LIMIT_RST;
      sum_limit_r  <= TOTAL_MAX;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_COMP_LIMIT) comp_limit_r <= cfg_pwdata[9:0];
      else sum_limit_r <= cfg_pwdata[17:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SUM_LIMIT) ? {14'd0, sum_limit_r}
                                                      : {22'd0, comp_limit_r};

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] last_r;
  logic [CW-1:0] pos_m1_r;
  logic [2:0]    op_r;
  logic [2:0]    cmd_r;
  logic [2:0]    status_r;
  rec_t          din_r;
  logic [9:0]    rd_r, gd_r, bd_r;
  logic [TW-1:0] racc_r, gacc_r, bacc_r;
  logic          out_valid_r;

  logic          accept;
  logic          out_free;
  logic [2:0]    dec_status;
  logic [2:0]    dec_op;
  logic [CW-1:0] dec_last;
  logic [HW-1:0] pos_ext, cnt_ext, pos_m1_ext;
  logic          empty, noent, bad_range;

  chain_ctrl_t   ctrl;
  rec_t          head;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign pos_ext    = HW'(in_ch.position);
  assign cnt_ext    = HW'(count_r);
  assign pos_m1_ext = pos_ext - HW'(1);
  assign empty      = (count_r == '0);
  assign noent      = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign bad_range  = (in_ch.red_in > comp_limit_r) || (in_ch.green_in > comp_limit_r) ||
                      (in_ch.blue_in > comp_limit_r);

  // decode the command against the current table
  always_comb begin
    dec_status = ST_OK;
    dec_op     = CH_HOLD;
    dec_last   = '0;
    case (in_ch.command)
      CMD_INSERT: begin
        if (bad_range) dec_status = ST_RANGE;
        else if (count_r >= CW'(DEPTH)) dec_status = ST_FULL;
        else dec_op = CH_INSERT;
      end
      CMD_DELETE: begin
        if (empty) dec_status = ST_EMPTY;
        else if (noent) dec_status = ST_NOENT;
        else dec_op = CH_DELETE;
      end
      CMD_SORT: begin
        if (empty) dec_status = ST_EMPTY;
        else begin
          dec_op   = CH_SORT;
          dec_last = count_r - CW'(1);
        end
      end
      CMD_READ: begin
        if (empty) dec_status = ST_EMPTY;
        else if (noent) dec_status = ST_NOENT;
        else begin
          dec_op   = CH_ROTATE;
          dec_last = CW'(DEPTH - 1);
        end
      end
      CMD_SUM: begin
        dec_op   = CH_ROTATE;
        dec_last = CW'(DEPTH - 1);
      end
      default: dec_status = ST_OK;
    endcase
  end

  // chain step control
  always_comb begin
    ctrl.op     = (state_r == S_WORK) ? op_r : CH_HOLD;
    ctrl.count  = IDX_W'(count_r);
    ctrl.pos_m1 = IDX_W'(pos_m1_r);
    ctrl.u      = IDX_W'(count_r - k_r);
    ctrl.x      = head;
    ctrl.din    = din_r;
  end

  rrts_chain #(.DEPTH(DEPTH)) u_chain (
    .clk (clk),
    .ctrl(ctrl),
    .head(head)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          k_nxt     = '0;
          state_nxt = (dec_op == CH_HOLD) ? S_DONE : S_WORK;
        end
      end
      S_WORK: begin
        k_nxt = k_r + CW'(1);
        if (k_r == last_r) begin
          state_nxt = S_DONE;
          if (op_r == CH_INSERT) count_nxt = count_r + CW'(1);
          else if (op_r == CH_DELETE) count_nxt = count_r - CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
    end
  end

  // latch the command, then gather read data and column sums at the head
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= dec_op;
      cmd_r    <= in_ch.command;
      status_r <= dec_status;
      last_r   <= dec_last;
      pos_m1_r <= pos_m1_ext[CW-1:0];
      din_r    <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
      rd_r     <= '0;
      gd_r     <= '0;
      bd_r     <= '0;
      racc_r   <= '0;
      gacc_r   <= '0;
      bacc_r   <= '0;
    end else if (state_r == S_WORK && op_r == CH_ROTATE) begin
      if (cmd_r == CMD_READ && k_r == pos_m1_r) begin
        rd_r <= head[29:20];
        gd_r <= head[19:10];
        bd_r <= head[9:0];
      end
      if (cmd_r == CMD_SUM && k_r < count_r) begin
        racc_r <= racc_r + TW'(head[29:20]);
        gacc_r <= gacc_r + TW'(head[19:10]);
        bacc_r <= bacc_r + TW'(head[9:0]);
      end
    end
  end

  // result register
  logic          load_out;
  logic [HW-1:0] held_ext;
  assign load_out = (state_r == S_DONE) && out_free;
  assign held_ext = HW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.status       <= status_r;
      out_ch.red_out      <= rd_r;
      out_ch.green_out    <= gd_r;
      out_ch.blue_out     <= bd_r;
      out_ch.entries_held <= held_ext[8:0];
      out_ch.red_total    <= (racc_r > TW'(TOTAL_MAX)) ? TOTAL_MAX : racc_r[17:0];
      out_ch.green_total  <= (gacc_r > TW'(TOTAL_MAX)) ? TOTAL_MAX : gacc_r[17:0];
      out_ch.blue_total   <= (bacc_r > TW'(TOTAL_MAX)) ? TOTAL_MAX : bacc_r[17:0];
      out_ch.red_over     <= (racc_r > TW'(sum_limit_r));
      out_ch.green_over   <= (gacc_r > TW'(sum_limit_r));
      out_ch.blue_over    <= (bacc_r > TW'(sum_limit_r));
    end
  end

  assign out_ch.valid = out_valid_r;

`include "assert_macros.svh"
  `RRTS_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "record count above depth")
  `RRTS_ASSERT_IMPL(a_busy_blocks, state_r != S_IDLE, !in_ch.ready, "accept while busy")
  `RRTS_ASSERT_NEXT(a_insert_count, state_r == S_WORK && op_r == CH_INSERT, count_r == CW'($past(count_r) + CW'(1)), "insert did not grow count")
  `RRTS_ASSERT_IMPL(a_done_keeps_result, state_r == S_DONE && !out_free, out_valid_r, "pending result lost")
endmodule
`default_nettype wire
